[src/can_sample_frame_scatter_defines.svh]
// Assertion macros shared by the RTL files of the frame scatter block.
`ifndef CAN_SAMPLE_FRAME_SCATTER_DEFINES_SVH
`define CAN_SAMPLE_FRAME_SCATTER_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define CSFS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("csfs: assertion failed");
// condition that must never be seen outside reset
`define CSFS_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("csfs: forbidden condition seen");
`else
`define CSFS_ASSERT(label, clk, rst, prop)
`define CSFS_NEVER(label, clk, rst, expr)
`endif
`endif

[src/csfs_pkg.sv]
`timescale 1ns / 1ps
package csfs_pkg;

   // geometry of the sample buffer
   localparam int ROWS           = 8;
   localparam int BOARDS         = 12;
   localparam int CHAN_PER_BOARD = 8;
   localparam int CHANNELS       = BOARDS * CHAN_PER_BOARD;
   localparam int BOARD_STRIDE   = 24;
   localparam int DATA_BASE      = 2;
   localparam int VALID_BASE     = 290;
   localparam int SAMPLE_BYTES   = 3;
   localparam int HALVES         = 2;

   // field widths
   localparam int BYTE_W = 8;
   localparam int ROW_W  = 3;
   localparam int COL_W  = 9;
   localparam int CHN_W  = $clog2(CHAN_PER_BOARD);
   localparam int BRD_W  = (BOARDS > 1) ? $clog2(BOARDS) : 1;
   localparam int IDX_W  = BRD_W + CHN_W;
   localparam int RAM_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W  = ($clog2(ROWS) > ROW_W) ? $clog2(ROWS) : ROW_W;

   localparam logic [BYTE_W-1:0] FIRST_BOARD_RESET = 8'h41;
   localparam logic [BYTE_W-1:0] VALID_MSB_MASK    = 8'h80;

   // result beats of one frame: three data bytes and one valid byte per half
   localparam int BEATS  = 8;
   localparam int BEAT_W = $clog2(BEATS);
   localparam logic [1:0] SUB_VALID = 2'd3;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_LOOK,
      FR_PUSH,
      FR_WRA,
      FR_WRB
   } front_state_type;

   // one classified frame as handed from front to back
   typedef struct packed {
      logic                                         err;
      logic [BRD_W-1:0]                             board;
      logic [CHN_W-1:0]                             chan_a;
      logic [CHN_W-1:0]                             chan_b;
      logic                                         flag_a;
      logic                                         flag_b;
      logic [ROW_W-1:0]                             row_a;
      logic [ROW_W-1:0]                             row_b;
      logic [HALVES-1:0][SAMPLE_BYTES-1:0][BYTE_W-1:0] data;
   } job_type;

   // advance a row counter, wrapping at ROWS
   function automatic logic [CNT_W-1:0] row_next(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] res;
      if (cnt >= CNT_W'(ROWS - 1)) begin
         res = '0;
      end else begin
         res = CNT_W'(cnt + 1'b1);
      end
      return res;
   endfunction

endpackage

[src/csfs_req_if.sv]
`timescale 1ns / 1ps
interface csfs_req_if;
   logic                           valid;
   logic                           ready;
   logic [csfs_pkg::BYTE_W-1:0]    board_id;
   logic [csfs_pkg::BYTE_W-1:0]    head_a;
   logic [csfs_pkg::BYTE_W-1:0]    data_a0;
   logic [csfs_pkg::BYTE_W-1:0]    data_a1;
   logic [csfs_pkg::BYTE_W-1:0]    data_a2;
   logic [csfs_pkg::BYTE_W-1:0]    head_b;
   logic [csfs_pkg::BYTE_W-1:0]    data_b0;
   logic [csfs_pkg::BYTE_W-1:0]    data_b1;
   logic [csfs_pkg::BYTE_W-1:0]    data_b2;

   modport source (
      output valid, board_id, head_a, data_a0, data_a1, data_a2,
             head_b, data_b0, data_b1, data_b2,
      input  ready
   );

   modport sink (
      input  valid, board_id, head_a, data_a0, data_a1, data_a2,
             head_b, data_b0, data_b1, data_b2,
      output ready
   );
endinterface

[src/csfs_rsp_if.sv]
`timescale 1ns / 1ps
interface csfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [csfs_pkg::ROW_W-1:0]     row;
   logic [csfs_pkg::COL_W-1:0]     column;
   logic [csfs_pkg::BYTE_W-1:0]    value;
   logic                           merge_or;
   logic                           id_error;
   logic                           last;

   modport source (
      output valid, row, column, value, merge_or, id_error, last,
      input  ready
   );

   modport sink (
      input  valid, row, column, value, merge_or, id_error, last,
      output ready
   );
endinterface

[src/can_sample_frame_scatter.sv]
`timescale 1ns / 1ps
// CAN sample frame scatter. Each accepted frame (board id plus two channel samples) becomes
// eight buffer write beats on rsp_ch, in the order: three data bytes of half a, the OR beat
// that sets half a's valid bit, then the same four beats for half b, with last on the eighth.
// A frame whose board index or channel is out of range gives one beat with id_error and last
// set and leaves every row counter as it was. Results leave one beat per cycle while rsp_ch is
// ready, so a stream of good frames is paced by the single result port; a rejected frame
// takes one result beat, so a run of rejected frames is paced by the front end. The front end
// classifies a frame and updates the 96 row counters (a two-read-port memory with per-channel
// valid flags, so reset needs no clearing pass) and runs ahead of the result side through a
// two-entry queue. The first result beat passes the front end's LOOK and PUSH states, the
// queue and the back end's output register. first_board_id is written through
// csr_wr_en / csr_wr_data; the user must write it only while the block is idle (not enforced).
module can_sample_frame_scatter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [csfs_pkg::BYTE_W-1:0] csr_wr_data,
   csfs_req_if.sink                    req_ch,
   csfs_rsp_if.source                  rsp_ch
);

   logic              push_valid;
   logic              push_ready;
   csfs_pkg::job_type push_job;
   logic              pop_valid;
   logic              pop_ready;
   csfs_pkg::job_type pop_job;

   csfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   csfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   csfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_ch    (rsp_ch)
   );

endmodule

[src/csfs_ram.sv]
`timescale 1ns / 1ps
module csfs_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // two registered read ports, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/csfs_queue.sv]
`timescale 1ns / 1ps
`include "can_sample_frame_scatter_defines.svh"
module csfs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  csfs_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output csfs_pkg::job_type pop_job
);

   csfs_pkg::job_type                  q_ff [csfs_pkg::QDEPTH];
   logic [csfs_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [csfs_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [csfs_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [csfs_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [csfs_pkg::QCNT_W-1:0]        count_ff;
   logic [csfs_pkg::QCNT_W-1:0]        count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != csfs_pkg::QCNT_W'(csfs_pkg::QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == csfs_pkg::QPTR_W'(csfs_pkg::QDEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = csfs_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == csfs_pkg::QPTR_W'(csfs_pkg::QDEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = csfs_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
         end
      end
      if (do_push && !do_pop) begin
         count_in = csfs_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = csfs_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

   `CSFS_ASSERT(a_empty_aligned, clock, reset, count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
   `CSFS_ASSERT(a_full_aligned, clock, reset, !push_ready |-> wr_ptr_ff == rd_ptr_ff)

endmodule

[src/csfs_front.sv]
`timescale 1ns / 1ps
`include "can_sample_frame_scatter_defines.svh"
module csfs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [csfs_pkg::BYTE_W-1:0]   csr_wr_data,
   csfs_req_if.sink                      req_ch,
   output logic                          push_valid,
   input  logic                          push_ready,
   output csfs_pkg::job_type             push_job
);

   csfs_pkg::front_state_type          state_ff;
   csfs_pkg::front_state_type          state_in;
   logic [csfs_pkg::BYTE_W-1:0]        first_id_ff;
   logic [csfs_pkg::BYTE_W-1:0]        first_id_in;
   csfs_pkg::job_type                  job_ff;
   csfs_pkg::job_type                  job_in;
   logic [csfs_pkg::CNT_W-1:0]         cnt_a_ff;
   logic [csfs_pkg::CNT_W-1:0]         cnt_a_in;
   logic [csfs_pkg::CNT_W-1:0]         cnt_b_ff;
   logic [csfs_pkg::CNT_W-1:0]         cnt_b_in;
   logic [csfs_pkg::CHANNELS-1:0]      vld_ff;
   logic [csfs_pkg::CHANNELS-1:0]      vld_in;

   logic                               accept;
   logic [csfs_pkg::BYTE_W-1:0]        board_w;
   logic                               err_w;
   logic [csfs_pkg::RAM_AW-1:0]        rd_addr_a;
   logic [csfs_pkg::RAM_AW-1:0]        rd_addr_b;
   logic [csfs_pkg::RAM_AW-1:0]        idx_a;
   logic [csfs_pkg::RAM_AW-1:0]        idx_b;
   logic [csfs_pkg::CNT_W-1:0]         next_a;
   logic [csfs_pkg::CNT_W-1:0]         next_b;
   logic                               ram_we;
   logic [csfs_pkg::RAM_AW-1:0]        ram_waddr;
   logic [csfs_pkg::CNT_W-1:0]         ram_wdata;
   logic [csfs_pkg::CNT_W-1:0]         ram_q_a;
   logic [csfs_pkg::CNT_W-1:0]         ram_q_b;
   logic                               ready_w;

   // classify the incoming frame
   assign accept  = req_ch.valid && ready_w;
   assign board_w = req_ch.board_id - first_id_ff;
   assign err_w   = (board_w >= csfs_pkg::BYTE_W'(csfs_pkg::BOARDS)) ||
                    (req_ch.head_a[3:0] >= 4'(csfs_pkg::CHAN_PER_BOARD)) ||
                    (req_ch.head_b[3:0] >= 4'(csfs_pkg::CHAN_PER_BOARD));
   assign rd_addr_a = csfs_pkg::RAM_AW'({board_w[csfs_pkg::BRD_W-1:0],
                                         req_ch.head_a[csfs_pkg::CHN_W-1:0]});
   assign rd_addr_b = csfs_pkg::RAM_AW'({board_w[csfs_pkg::BRD_W-1:0],
                                         req_ch.head_b[csfs_pkg::CHN_W-1:0]});
   assign idx_a = csfs_pkg::RAM_AW'({job_ff.board, job_ff.chan_a});
   assign idx_b = csfs_pkg::RAM_AW'({job_ff.board, job_ff.chan_b});

   // counter updates; a shared channel advances twice from the same start
   assign next_a = csfs_pkg::row_next(cnt_a_ff);
   assign next_b = csfs_pkg::row_next((idx_a == idx_b) ? next_a : cnt_b_ff);

   assign req_ch.ready = ready_w;
   assign push_job     = job_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csfs_pkg::FR_IDLE: begin
            if (accept) begin
               state_in = csfs_pkg::FR_LOOK;
            end
         end
         csfs_pkg::FR_LOOK: begin
            state_in = csfs_pkg::FR_PUSH;
         end
         csfs_pkg::FR_PUSH: begin
            if (push_ready) begin
               state_in = job_ff.err ? csfs_pkg::FR_IDLE : csfs_pkg::FR_WRA;
            end
         end
         csfs_pkg::FR_WRA: begin
            state_in = csfs_pkg::FR_WRB;
         end
         csfs_pkg::FR_WRB: begin
            state_in = csfs_pkg::FR_IDLE;
         end
         default: begin
            state_in = csfs_pkg::FR_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      ready_w    = 1'b0;
      push_valid = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = idx_a;
      ram_wdata  = next_a;
      case (state_ff)
         csfs_pkg::FR_IDLE: begin
            ready_w = 1'b1;
         end
         csfs_pkg::FR_PUSH: begin
            push_valid = 1'b1;
         end
         csfs_pkg::FR_WRA: begin
            ram_we = 1'b1;
         end
         csfs_pkg::FR_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = idx_b;
            ram_wdata = next_b;
         end
         default: begin
            ready_w = 1'b0;
         end
      endcase
   end

   // capture frame on accept, rows once the counters are read
   always_comb begin
      job_in   = job_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      if (accept) begin
         job_in.err     = err_w;
         job_in.board   = board_w[csfs_pkg::BRD_W-1:0];
         job_in.chan_a  = req_ch.head_a[csfs_pkg::CHN_W-1:0];
         job_in.chan_b  = req_ch.head_b[csfs_pkg::CHN_W-1:0];
         job_in.flag_a  = req_ch.head_a[7];
         job_in.flag_b  = req_ch.head_b[7];
         job_in.data[0] = {req_ch.data_a2, req_ch.data_a1, req_ch.data_a0};
         job_in.data[1] = {req_ch.data_b2, req_ch.data_b1, req_ch.data_b0};
      end
      if (state_ff == csfs_pkg::FR_LOOK) begin
         cnt_a_in     = vld_ff[idx_a] ? ram_q_a : '0;
         cnt_b_in     = vld_ff[idx_b] ? ram_q_b : '0;
         job_in.row_a = cnt_a_in[csfs_pkg::ROW_W-1:0];
         job_in.row_b = cnt_b_in[csfs_pkg::ROW_W-1:0];
      end
   end

   // mark written counters as holding a value
   always_comb begin
      vld_in = vld_ff;
      if (ram_we) begin
         vld_in[ram_waddr] = 1'b1;
      end
   end

   // hold board id register
   always_comb begin
      first_id_in = first_id_ff;
      if (csr_wr_en) begin
         first_id_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= csfs_pkg::FR_IDLE;
         first_id_ff <= csfs_pkg::FIRST_BOARD_RESET;
         vld_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         first_id_ff <= first_id_in;
         vld_ff      <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      cnt_a_ff <= cnt_a_in;
      cnt_b_ff <= cnt_b_in;
   end

   csfs_ram #(
      .WIDTH (csfs_pkg::CNT_W),
      .DEPTH (csfs_pkg::CHANNELS)
   ) u_row_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_q_a),
      .rd_data_b (ram_q_b)
   );

   `CSFS_NEVER(a_no_write_on_error, clock, reset, ram_we && job_ff.err)
   `CSFS_NEVER(a_no_accept_while_updating, clock, reset, accept && (ram_we || push_valid))

endmodule

[src/csfs_back.sv]
`timescale 1ns / 1ps
`include "can_sample_frame_scatter_defines.svh"
module csfs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  csfs_pkg::job_type pop_job,
   csfs_rsp_if.source        rsp_ch
);

   csfs_pkg::job_type                  job_ff;
   csfs_pkg::job_type                  job_in;
   logic                               have_ff;
   logic                               have_in;
   logic [csfs_pkg::BEAT_W-1:0]        beat_ff;
   logic [csfs_pkg::BEAT_W-1:0]        beat_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [csfs_pkg::ROW_W-1:0]         rsp_row_ff;
   logic [csfs_pkg::ROW_W-1:0]         rsp_row_in;
   logic [csfs_pkg::COL_W-1:0]         rsp_col_ff;
   logic [csfs_pkg::COL_W-1:0]         rsp_col_in;
   logic [csfs_pkg::BYTE_W-1:0]        rsp_val_ff;
   logic [csfs_pkg::BYTE_W-1:0]        rsp_val_in;
   logic                               rsp_or_ff;
   logic                               rsp_or_in;
   logic                               rsp_err_ff;
   logic                               rsp_err_in;
   logic                               rsp_last_ff;
   logic                               rsp_last_in;

   logic                               advance;
   logic                               last_beat;
   logic                               half;
   logic [1:0]                         sub;
   logic [csfs_pkg::CHN_W-1:0]         chan;
   logic                               flag;
   logic [csfs_pkg::COL_W-1:0]         base_col;

   // issue one beat whenever the output register is free or drained
   assign advance   = have_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign last_beat = job_ff.err || (beat_ff == csfs_pkg::BEAT_W'(csfs_pkg::BEATS - 1));
   assign pop_ready = !have_ff || (advance && last_beat);

   assign half     = beat_ff[csfs_pkg::BEAT_W-1];
   assign sub      = beat_ff[1:0];
   assign chan     = half ? job_ff.chan_b : job_ff.chan_a;
   assign flag     = half ? job_ff.flag_b : job_ff.flag_a;
   assign base_col = csfs_pkg::COL_W'(csfs_pkg::DATA_BASE) +
                     csfs_pkg::COL_W'(job_ff.board) * csfs_pkg::COL_W'(csfs_pkg::BOARD_STRIDE) +
                     csfs_pkg::COL_W'(chan) * csfs_pkg::COL_W'(csfs_pkg::SAMPLE_BYTES);

   // track the frame in work and its beat
   always_comb begin
      job_in  = job_ff;
      have_in = have_ff;
      beat_in = beat_ff;
      if (pop_valid && pop_ready) begin
         job_in  = pop_job;
         have_in = 1'b1;
         beat_in = '0;
      end else if (advance && last_beat) begin
         have_in = 1'b0;
      end else if (advance) begin
         beat_in = csfs_pkg::BEAT_W'(beat_ff + 1'b1);
      end
   end

   // build the next result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_or_in    = rsp_or_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (job_ff.err) begin
            rsp_row_in  = '0;
            rsp_col_in  = '0;
            rsp_val_in  = '0;
            rsp_or_in   = 1'b0;
            rsp_err_in  = 1'b1;
            rsp_last_in = 1'b1;
         end else begin
            rsp_row_in  = half ? job_ff.row_b : job_ff.row_a;
            rsp_err_in  = 1'b0;
            rsp_last_in = half && (sub == csfs_pkg::SUB_VALID);
            if (sub == csfs_pkg::SUB_VALID) begin
               rsp_col_in = csfs_pkg::COL_W'(csfs_pkg::VALID_BASE) +
                            csfs_pkg::COL_W'(job_ff.board);
               rsp_val_in = flag ? (csfs_pkg::VALID_MSB_MASK >> chan) : '0;
               rsp_or_in  = 1'b1;
            end else begin
               rsp_col_in = base_col + csfs_pkg::COL_W'(sub);
               rsp_val_in = job_ff.data[half][sub];
               rsp_or_in  = 1'b0;
            end
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      beat_ff     <= beat_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_or_ff   <= rsp_or_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.row      = rsp_row_ff;
   assign rsp_ch.column   = rsp_col_ff;
   assign rsp_ch.value    = rsp_val_ff;
   assign rsp_ch.merge_or = rsp_or_ff;
   assign rsp_ch.id_error = rsp_err_ff;
   assign rsp_ch.last     = rsp_last_ff;

   `CSFS_ASSERT(a_error_beat_is_bare, clock, reset, rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && !rsp_or_ff && rsp_col_ff == '0 && rsp_val_ff == '0)

endmodule

[verif/can_sample_frame_scatter_test.sv]
`timescale 1ns / 1ps
module can_sample_frame_scatter_test;

   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 16;
   localparam int MAX_REPORTS  = 10;
   localparam int RESET_CYCLES = 12;
   localparam logic [csfs_pkg::BYTE_W-1:0] FLAG_MASK = 8'h80;

   // one received frame as offered on the request channel
   typedef struct packed {
      logic [csfs_pkg::BYTE_W-1:0]      board_id;
      logic [csfs_pkg::BYTE_W-1:0]      head_a;
      logic [2:0][csfs_pkg::BYTE_W-1:0] data_a;
      logic [csfs_pkg::BYTE_W-1:0]      head_b;
      logic [2:0][csfs_pkg::BYTE_W-1:0] data_b;
   } frame_type;

   // one buffer write command as seen on the result channel
   typedef struct packed {
      logic [csfs_pkg::ROW_W-1:0]  row;
      logic [csfs_pkg::COL_W-1:0]  column;
      logic [csfs_pkg::BYTE_W-1:0] value;
      logic                        merge_or;
      logic                        id_error;
      logic                        last;
   } write_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_wr_en;
   logic [csfs_pkg::BYTE_W-1:0] csr_wr_data;

   csfs_req_if req_bus ();
   csfs_rsp_if rsp_bus ();

   can_sample_frame_scatter dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus)
   );

   // predictor state: board id base and per-channel row counters
   logic [csfs_pkg::BYTE_W-1:0] board_base = csfs_pkg::FIRST_BOARD_RESET;
   int                          row_count [csfs_pkg::CHANNELS];

   frame_type frames_to_send [$];
   write_type expected_writes [$];

   int   frames_queued   = 0;
   int   frames_accepted = 0;
   int   frames_rejected = 0;
   int   writes_checked  = 0;
   int   base_writes     = 0;
   int   mismatches      = 0;
   int   quiet_cycles    = 0;
   bit   req_taken       = 1'b0;
   bit   send_idle_on    = 1'b1;
   bit   recv_idle_on    = 1'b1;
   bit   long_hold_pending = 1'b0;
   int   send_gap        = 0;
   int   hold_left       = 0;
   logic drive_valid;
   frame_type next_frame;
   frame_type seen_frame;
   write_type seen_write;
   write_type want_write;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // idle length: mostly short, now and then long
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // expand one frame into its write commands and advance the row counters
   task automatic scatter_frame(input frame_type f);
      logic [csfs_pkg::BYTE_W-1:0]      brd;
      logic [3:0]                       chan [2];
      logic [csfs_pkg::BYTE_W-1:0]      head [2];
      logic [2:0][csfs_pkg::BYTE_W-1:0] bytes [2];
      int                               idx [2];
      logic [csfs_pkg::ROW_W-1:0]       row [2];
      write_type                        w;
      brd     = f.board_id - board_base;
      head[0] = f.head_a;
      head[1] = f.head_b;
      bytes[0] = f.data_a;
      bytes[1] = f.data_b;
      for (int h = 0; h < csfs_pkg::HALVES; h++) begin
         chan[h] = head[h][3:0];
         idx[h]  = brd * csfs_pkg::CHAN_PER_BOARD + chan[h];
      end
      w = '0;
      // reject bad board or channel with a single error beat
      if (brd >= csfs_pkg::BOARDS || chan[0] >= csfs_pkg::CHAN_PER_BOARD ||
          chan[1] >= csfs_pkg::CHAN_PER_BOARD) begin
         w.id_error = 1'b1;
         w.last     = 1'b1;
         expected_writes.push_back(w);
         frames_rejected++;
         return;
      end
      // both halves use the rows read before any advance
      for (int h = 0; h < csfs_pkg::HALVES; h++) begin
         row[h] = csfs_pkg::ROW_W'(row_count[idx[h]]);
      end
      for (int h = 0; h < csfs_pkg::HALVES; h++) begin
         for (int b = 0; b < csfs_pkg::SAMPLE_BYTES; b++) begin
            w          = '0;
            w.row      = row[h];
            w.column   = csfs_pkg::COL_W'(csfs_pkg::DATA_BASE + brd * csfs_pkg::BOARD_STRIDE +
                                          chan[h] * csfs_pkg::SAMPLE_BYTES + b);
            w.value    = bytes[h][b];
            expected_writes.push_back(w);
         end
         w          = '0;
         w.row      = row[h];
         w.column   = csfs_pkg::COL_W'(csfs_pkg::VALID_BASE + brd);
         w.value    = head[h][7] ? (FLAG_MASK >> chan[h]) : '0;
         w.merge_or = 1'b1;
         w.last     = (h == csfs_pkg::HALVES - 1);
         expected_writes.push_back(w);
      end
      // advance a then b, each wrapping on its own
      for (int h = 0; h < csfs_pkg::HALVES; h++) begin
         row_count[idx[h]] = (row_count[idx[h]] + 1 >= csfs_pkg::ROWS) ? 0
                                                                      : row_count[idx[h]] + 1;
      end
   endtask

   task automatic note_mismatch(input string what, input write_type want, input write_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("Mismatch (%s) at %0t: expected row %0d col %0d val %02h or %0b err %0b last %0b",
                  what, $realtime, want.row, want.column, want.value, want.merge_or,
                  want.id_error, want.last);
         $display("   got row %0d col %0d val %02h or %0b err %0b last %0b",
                  got.row, got.column, got.value, got.merge_or, got.id_error, got.last);
      end
   endtask

   task automatic queue_frame(input logic [csfs_pkg::BYTE_W-1:0] bid,
                              input logic [csfs_pkg::BYTE_W-1:0] ha,
                              input logic [23:0] da, input logic [csfs_pkg::BYTE_W-1:0] hb,
                              input logic [23:0] db);
      frame_type f;
      f.board_id = bid;
      f.head_a   = ha;
      f.data_a   = da;
      f.head_b   = hb;
      f.data_b   = db;
      frames_to_send.push_back(f);
      frames_queued++;
   endtask

   // mostly well-formed frames packed on a few channels, the rest noise
   function automatic frame_type random_frame(input logic [csfs_pkg::BYTE_W-1:0] base);
      frame_type f;
      int        pick;
      int        brd;
      int        ch_a;
      int        ch_b;
      pick     = $urandom_range(0, 99);
      f.data_a = 24'($urandom);
      f.data_b = 24'($urandom);
      if (pick < 85) begin
         brd  = $urandom_range(0, 1) ? $urandom_range(0, 1) * (csfs_pkg::BOARDS - 1)
                                     : $urandom_range(0, csfs_pkg::BOARDS - 1);
         ch_a = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                     : $urandom_range(0, csfs_pkg::CHAN_PER_BOARD - 1);
         ch_b = (pick < 20) ? ch_a : $urandom_range(0, csfs_pkg::CHAN_PER_BOARD - 1);
         f.board_id = csfs_pkg::BYTE_W'(base + brd);
         f.head_a   = {1'($urandom), 3'($urandom), 4'(ch_a)};
         f.head_b   = {1'($urandom), 3'($urandom), 4'(ch_b)};
      end else begin
         f.board_id = csfs_pkg::BYTE_W'($urandom);
         f.head_a   = csfs_pkg::BYTE_W'($urandom);
         f.head_b   = csfs_pkg::BYTE_W'($urandom);
      end
      return f;
   endfunction

   task automatic write_board_base(input logic [csfs_pkg::BYTE_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // hold the sender until every frame is taken and every write has come back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (frames_accepted != frames_queued || expected_writes.size() != 0);
   endtask

   task automatic run_phase(input logic [csfs_pkg::BYTE_W-1:0] base, input int count,
                            input bit send_idle, input bit recv_idle, input bit long_hold);
      write_board_base(base);
      send_idle_on = send_idle;
      recv_idle_on = recv_idle;
      if (long_hold) begin
         long_hold_pending = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
         frames_to_send.push_back(random_frame(base));
         frames_queued++;
      end
      wait_drained();
   endtask

   // driver: offer frames from the queue, with random idle gaps between frames
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         drive_valid = req_bus.valid;
         if (req_taken) begin
            drive_valid = 1'b0;
            if (send_idle_on && $urandom_range(0, 1) == 0) begin
               send_gap = gap_len();
            end
         end
         if (!drive_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (frames_to_send.size() != 0) begin
               next_frame       = frames_to_send.pop_front();
               req_bus.board_id <= next_frame.board_id;
               req_bus.head_a   <= next_frame.head_a;
               req_bus.data_a0  <= next_frame.data_a[0];
               req_bus.data_a1  <= next_frame.data_a[1];
               req_bus.data_a2  <= next_frame.data_a[2];
               req_bus.head_b   <= next_frame.head_b;
               req_bus.data_b0  <= next_frame.data_b[0];
               req_bus.data_b1  <= next_frame.data_b[1];
               req_bus.data_b2  <= next_frame.data_b[2];
               drive_valid = 1'b1;
            end
         end
         req_bus.valid <= drive_valid;
      end
   end

   // receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (long_hold_pending) begin
            hold_left = LONG_HOLD;
            long_hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            hold_left = gap_len() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // monitor: predict on accepted frames, check accepted write beats
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         if (csr_wr_en) begin
            board_base = csr_wr_data;
            base_writes++;
         end
         if (req_taken) begin
            seen_frame.board_id = req_bus.board_id;
            seen_frame.head_a   = req_bus.head_a;
            seen_frame.data_a   = {req_bus.data_a2, req_bus.data_a1, req_bus.data_a0};
            seen_frame.head_b   = req_bus.head_b;
            seen_frame.data_b   = {req_bus.data_b2, req_bus.data_b1, req_bus.data_b0};
            scatter_frame(seen_frame);
            frames_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_write.row      = rsp_bus.row;
            seen_write.column   = rsp_bus.column;
            seen_write.value    = rsp_bus.value;
            seen_write.merge_or = rsp_bus.merge_or;
            seen_write.id_error = rsp_bus.id_error;
            seen_write.last     = rsp_bus.last;
            if (expected_writes.size() == 0) begin
               note_mismatch("unexpected beat", '0, seen_write);
            end else begin
               want_write = expected_writes.pop_front();
               writes_checked++;
               if (seen_write.row !== want_write.row ||
                   seen_write.column !== want_write.column ||
                   seen_write.value !== want_write.value ||
                   seen_write.merge_or !== want_write.merge_or ||
                   seen_write.id_error !== want_write.id_error ||
                   seen_write.last !== want_write.last) begin
                  note_mismatch("field", want_write, seen_write);
               end
            end
         end
         // watchdog on cycles with no handshake at all
         if (req_taken || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d writes outstanding",
                     quiet_cycles, expected_writes.size());
            $display("FAIL can_sample_frame_scatter");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_bus.valid    = 1'b0;
      req_bus.board_id = '0;
      req_bus.head_a   = '0;
      req_bus.data_a0  = '0;
      req_bus.data_a1  = '0;
      req_bus.data_a2  = '0;
      req_bus.head_b   = '0;
      req_bus.data_b0  = '0;
      req_bus.data_b1  = '0;
      req_bus.data_b2  = '0;
      rsp_bus.ready    = 1'b0;
      for (int i = 0; i < csfs_pkg::CHANNELS; i++) begin
         row_count[i] = 0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under the reset board base
      write_board_base(csfs_pkg::FIRST_BOARD_RESET);
      queue_frame(8'h41, 8'h80, 24'h000000, 8'h87, 24'hFFFFFF);
      queue_frame(8'h4C, 8'h87, 24'hFFFFFF, 8'h00, 24'h000000);
      queue_frame(8'h4C, 8'hF7, 24'hA5A55A, 8'h70, 24'h5AA5A5);
      // board past the last, board below the first, bad channels
      queue_frame(8'h4D, 8'h81, 24'h123456, 8'h82, 24'h654321);
      queue_frame(8'h40, 8'h81, 24'h111111, 8'h82, 24'h222222);
      queue_frame(8'h41, 8'h08, 24'h333333, 8'h01, 24'h444444);
      queue_frame(8'h41, 8'h01, 24'h555555, 8'h0F, 24'h666666);
      queue_frame(8'h41, 8'hFF, 24'h777777, 8'hFF, 24'h888888);
      queue_frame(8'hFF, 8'h81, 24'h999999, 8'h82, 24'hAAAAAA);
      queue_frame(8'h00, 8'h81, 24'hBBBBBB, 8'h82, 24'hCCCCCC);
      // same channel in both halves until the counter wraps
      for (int i = 0; i < 5; i++) begin
         queue_frame(8'h45, 8'h83, 24'($urandom), 8'h83, 24'($urandom));
      end
      queue_frame(8'h41, 8'h83, 24'($urandom), 8'h04, 24'($urandom));
      wait_drained();

      // random phases across board base settings, extremes included
      run_phase(csfs_pkg::FIRST_BOARD_RESET, 35, 1'b1, 1'b1, 1'b1);
      run_phase(8'h00, 20, 1'b0, 1'b0, 1'b0);
      run_phase(8'hFF, 20, 1'b1, 1'b1, 1'b0);
      run_phase(csfs_pkg::BYTE_W'($urandom), 15, 1'b1, 1'b0, 1'b0);
      run_phase(csfs_pkg::FIRST_BOARD_RESET, 20, 1'b1, 1'b1, 1'b0);

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Run covered %0d frames (%0d rejected) and %0d checked write beats",
               frames_accepted, frames_rejected, writes_checked);
      $display("over %0d board base settings, with a %0d cycle result stall; %0d mismatches",
               base_writes, LONG_HOLD, mismatches);
      if (mismatches == 0 && expected_writes.size() == 0) begin
         $display("PASS can_sample_frame_scatter");
      end else begin
         $display("FAIL can_sample_frame_scatter");
      end
      $finish;
   end

endmodule
